// ===== hdl/gtfe_pkg.sv =====
// shared types and fixed-point constants for the gelu tanh datapath
`timescale 1ns / 1ps
`default_nettype none

package gtfe_pkg;

  // fraction bits of the internal polynomial format and of the q30 constants
  localparam int UF = 26;
  localparam int QF = 30;

  // internal widths, set by the clamp of |x| to 8 and of |u| to 8
  localparam int XQ_W   = 30;
  localparam int X2_W   = 33;
  localparam int X3_W   = 36;
  localparam int C3_W   = 31;
  localparam int S_W    = 32;
  localparam int UR_W   = 31;
  localparam int U_W    = 30;
  localparam int T_W    = 31;
  localparam int TI_W   = 5;
  localparam int TF_W   = 26;
  localparam int K_W    = 31;
  localparam int DV_W   = 55;
  localparam int Q_W    = 31;
  localparam int PART_W = 32;

  // q30 coefficients
  localparam logic [29:0] C_SQ2PI = 30'd856722024;
  localparam logic [25:0] C_CUBIC = 26'd48012366;
  localparam logic [30:0] C_LOG2E = 31'd1549082004;
  localparam logic [29:0] C_SLOPE = 30'd1065496872;
  localparam logic [29:0] C_ICEPT = 30'd1016955152;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // saturation level of u, 8.0 in the internal format
  localparam logic [U_W-1:0] U_SAT = 30'd536870912;

  // control bits that travel with each transaction
  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
  } gtfe_tag_t;

endpackage

`default_nettype wire

// ===== hdl/gtfe_front.sv =====
// input skid, absolute value, cubic polynomial and exponent stages
`timescale 1ns / 1ps
`default_nettype none

module gtfe_front import gtfe_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] x_in,
  input  logic                  last_in,
  output gtfe_tag_t             tag_o,
  output logic [DATA_WIDTH-1:0] ax_o,
  output logic [DV_W-1:0]       dvsr_o
);

  localparam int          NSTG  = 9;
  localparam int          SHIFT = FRAC_BITS - UF;
  localparam int          SHR   = (SHIFT >= 0) ? SHIFT : 0;
  localparam int          SHL   = (SHIFT >= 0) ? 0 : -SHIFT;
  localparam logic [63:0] LIM   = 64'd8 << FRAC_BITS;

  // skid register
  logic                  skid_v;
  logic [DATA_WIDTH-1:0] skid_x;
  logic                  skid_last;

  // stage registers
  gtfe_tag_t             tag  [NSTG];
  logic [DATA_WIDTH-1:0] ax_r [NSTG];
  logic [XQ_W-1:0]       xq1, xq2, xq3, xq4;
  logic [X2_W-1:0]       x2;
  logic [X3_W-1:0]       x3;
  logic [C3_W-1:0]       c3;
  logic [S_W-1:0]        s;
  logic [U_W-1:0]        u;
  logic [T_W-1:0]        t;
  logic [K_W-1:0]        k;
  logic [TI_W-1:0]       ti8;
  logic [DV_W-1:0]       dvsr;

  // combinational
  logic                       accept;
  logic                       src_v;
  logic [DATA_WIDTH-1:0]      src_x;
  logic                       src_last;
  logic                       neg_c;
  logic [DATA_WIDTH-1:0]      ax_c;
  logic [63:0]                ax_ext;
  logic [63:0]                cl;
  logic [XQ_W-1:0]            xq_c;
  logic [2*XQ_W-1:0]          p_x2;
  logic [X2_W+XQ_W-1:0]       p_x3;
  logic [26+X3_W-1:0]         p_c3;
  logic [S_W-1:0]             s_c;
  logic [30+S_W-1:0]          p_u;
  logic [UR_W-1:0]            u_raw;
  logic [U_W-1:0]             u_c;
  logic [2*T_W-1:0]           p_t;
  logic [TF_W-1:0]            tf;
  logic [30+TF_W-1:0]         p_k;
  logic [K_W-1:0]             k_c;
  logic [DV_W-1:0]            dvsr_c;

  // input side: one extra transaction is parked while the pipe is stalled
  assign in_ready = !skid_v;
  assign accept   = in_valid && in_ready;
  assign src_v    = skid_v || in_valid;
  assign src_x    = skid_v ? skid_x : x_in;
  assign src_last = skid_v ? skid_last : last_in;

  // magnitude and clamp to 8, converted to the internal format
  always_comb begin
    neg_c  = src_x[DATA_WIDTH-1];
    ax_c   = neg_c ? (~src_x + 1'b1) : src_x;
    ax_ext = 64'(ax_c);
    cl     = (ax_ext < LIM) ? ax_ext : LIM;
    xq_c   = XQ_W'((cl >> SHR) << SHL);
  end

  // polynomial and exponent arithmetic
  always_comb begin
    p_x2   = xq1 * xq1;
    p_x3   = x2 * xq2;
    p_c3   = C_CUBIC * x3;
    s_c    = S_W'(xq4) + S_W'(c3);
    p_u    = C_SQ2PI * s;
    u_raw  = p_u[QF+UR_W-1:QF];
    u_c    = (u_raw > UR_W'(U_SAT)) ? U_SAT : u_raw[U_W-1:0];
    p_t    = {u, 1'b0} * C_LOG2E;
    tf     = t[TF_W-1:0];
    p_k    = C_SLOPE * tf;
    k_c    = K_W'(p_k[UF+30-1:UF]) + K_W'(C_ICEPT);
    dvsr_c = (DV_W'(k) << ti8) + DV_W'(ONE_Q30);
  end

  // control: valid bits and skid state
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
      for (int i = 0; i < NSTG; i++) tag[i] <= '0;
    end else begin
      if (en) begin
        skid_v <= 1'b0;
      end else if (accept) begin
        skid_v <= 1'b1;
      end
      if (en) begin
        tag[0] <= '{valid: src_v, last: src_last, neg: neg_c};
        for (int i = 1; i < NSTG; i++) tag[i] <= tag[i-1];
      end
    end
  end

  // skid payload
  always_ff @(posedge clk) begin
    if (!en && accept) begin
      skid_x    <= x_in;
      skid_last <= last_in;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= ax_c;
      for (int i = 1; i < NSTG; i++) ax_r[i] <= ax_r[i-1];
      xq1  <= xq_c;
      x2   <= p_x2[UF+X2_W-1:UF];
      xq2  <= xq1;
      x3   <= p_x3[UF+X3_W-1:UF];
      xq3  <= xq2;
      c3   <= p_c3[QF+C3_W-1:QF];
      xq4  <= xq3;
      s    <= s_c;
      u    <= u_c;
      t    <= p_t[QF+T_W-1:QF];
      k    <= k_c;
      ti8  <= t[T_W-1:TF_W];
      dvsr <= dvsr_c;
    end
  end

  assign tag_o  = tag[NSTG-1];
  assign ax_o   = ax_r[NSTG-1];
  assign dvsr_o = dvsr;

endmodule

`default_nettype wire

// ===== hdl/gtfe_div.sv =====
// pipelined restoring divider, one quotient bit per stage, for 2^61 / divisor
`timescale 1ns / 1ps
`default_nettype none

module gtfe_div import gtfe_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  gtfe_tag_t             tag_i,
  input  logic [DATA_WIDTH-1:0] ax_i,
  input  logic [DV_W-1:0]       dvsr_i,
  output gtfe_tag_t             tag_o,
  output logic [DATA_WIDTH-1:0] ax_o,
  output logic [Q_W-1:0]        q_o
);

  // per-stage registers; remainder and divisor are not kept after the last bit
  gtfe_tag_t             tag_r [Q_W];
  logic [DATA_WIDTH-1:0] ax_r  [Q_W];
  logic [Q_W-1:0]        q_r   [Q_W];
  logic [DV_W-1:0]       p_r   [Q_W-1];
  logic [DV_W-1:0]       d_r   [Q_W-1];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    gtfe_tag_t             tag_p;
    logic [DATA_WIDTH-1:0] ax_p;
    logic [Q_W-1:0]        q_p;
    logic [DV_W-1:0]       p_p;
    logic [DV_W-1:0]       d_p;
    logic [DV_W:0]         pp;
    logic [DV_W:0]         diff;
    logic                  ge;
    logic [DV_W-1:0]       p_next;

    // stage inputs; the first stage starts from the top dividend bits
    if (i == 0) begin : g_first
      assign tag_p = tag_i;
      assign ax_p  = ax_i;
      assign q_p   = '0;
      assign p_p   = DV_W'(ONE_Q30);
      assign d_p   = dvsr_i;
    end else begin : g_next
      assign tag_p = tag_r[i-1];
      assign ax_p  = ax_r[i-1];
      assign q_p   = q_r[i-1];
      assign p_p   = p_r[i-1];
      assign d_p   = d_r[i-1];
    end

    // shift, compare and subtract
    always_comb begin
      pp     = {p_p, 1'b0};
      diff   = pp - {1'b0, d_p};
      ge     = (pp >= {1'b0, d_p});
      p_next = ge ? diff[DV_W-1:0] : pp[DV_W-1:0];
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_r[i] <= '0;
      end else if (en) begin
        tag_r[i] <= tag_p;
      end
    end

    // quotient and passthrough payload
    always_ff @(posedge clk) begin
      if (en) begin
        ax_r[i] <= ax_p;
        q_r[i]  <= {q_p[Q_W-2:0], ge};
      end
    end

    if (i < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          p_r[i] <= p_next;
          d_r[i] <= d_p;
        end
      end
    end
  end

  assign tag_o = tag_r[Q_W-1];
  assign ax_o  = ax_r[Q_W-1];
  assign q_o   = q_r[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/gtfe_back.sv =====
// 1 + tanh, final scaling by |x|, sign and output register
`timescale 1ns / 1ps
`default_nettype none

module gtfe_back import gtfe_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  gtfe_tag_t                    tag_i,
  input  logic [DATA_WIDTH-1:0]        ax_i,
  input  logic [Q_W-1:0]               q_i,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] y_out,
  output logic                         last_out
);

  gtfe_tag_t             tag [4];
  logic [DATA_WIDTH-1:0] ax1;
  logic [Q_W-1:0]        onep;
  logic [PART_W+Q_W-1:0] lp;
  logic [PART_W+Q_W-1:0] hp;
  logic [63:0]           m;
  logic                  rem;

  logic [Q_W:0]          inv_c;
  logic [Q_W-1:0]        onep_c;
  logic [63:0]           ax64;
  logic [63:0]           m_c;
  logic [63:0]           y_c;

  // 1 + tanh: the quotient itself for negative x, 2 - quotient otherwise
  always_comb begin
    inv_c  = {1'b1, {Q_W{1'b0}}} - {1'b0, q_i};
    onep_c = tag_i.neg ? q_i : inv_c[Q_W-1:0];
  end

  // product split into 32-bit halves of |x|, then floor shift and sign
  always_comb begin
    ax64 = 64'(ax1);
    m_c  = {hp, 1'b0} + 64'(lp[PART_W+Q_W-1:Q_W]);
    y_c  = tag[2].neg ? (~m + 64'(!rem)) : m;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) tag[i] <= '0;
    end else if (en) begin
      tag[0] <= tag_i;
      for (int i = 1; i < 4; i++) tag[i] <= tag[i-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      onep  <= onep_c;
      ax1   <= ax_i;
      lp    <= ax64[PART_W-1:0] * onep;
      hp    <= ax64[63:PART_W] * onep;
      m     <= m_c;
      rem   <= |lp[Q_W-1:0];
      y_out <= y_c[DATA_WIDTH-1:0];
    end
  end

  assign out_valid = tag[3].valid;
  assign last_out  = tag[3].last;

endmodule

`default_nettype wire

// ===== hdl/gelu_tanh_fast_exp_top.sv =====
// top level of the streaming gelu (tanh form) activation unit
// One transaction per clock in steady state while results are taken, in three parts:
// 9 stages form |x|, the cubic u, the exponent and the divisor, 31 stages of
// the pipelined divider each resolve one quotient bit for 2 / (e + 1), and 4
// stages form 1 + tanh, multiply by |x| and apply the sign. The whole pipe
// advances whenever the output register is empty or taken; while a result
// waits, one more input transaction is held in an input skid register.
// x_in and y_out are signed with FRAC_BITS fraction bits; last_in is carried
// to last_out unchanged.
`timescale 1ns / 1ps
`default_nettype none

module gelu_tanh_fast_exp_top import gtfe_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] x_in,
  input  logic                         last_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] y_out,
  output logic                         last_out
);

  logic                  en;
  gtfe_tag_t             tag_f;
  gtfe_tag_t             tag_d;
  logic [DATA_WIDTH-1:0] ax_f;
  logic [DATA_WIDTH-1:0] ax_d;
  logic [DV_W-1:0]       dvsr;
  logic [Q_W-1:0]        q;

  // global pipe advance
  assign en = !out_valid || out_ready;

  gtfe_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .x_in     (x_in),
    .last_in  (last_in),
    .tag_o    (tag_f),
    .ax_o     (ax_f),
    .dvsr_o   (dvsr)
  );

  gtfe_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .tag_i  (tag_f),
    .ax_i   (ax_f),
    .dvsr_i (dvsr),
    .tag_o  (tag_d),
    .ax_o   (ax_d),
    .q_o    (q)
  );

  gtfe_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tag_i     (tag_d),
    .ax_i      (ax_d),
    .q_i       (q),
    .out_valid (out_valid),
    .y_out     (y_out),
    .last_out  (last_out)
  );

endmodule

`default_nettype wire

// ===== hdl/gtfe_checker.sv =====
// port-level checks for the gelu unit and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module gtfe_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [DATA_WIDTH-1:0] y_out,
  input wire                  last_out
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(y_out) && $stable(last_out))
    else $error("stalled result changed");

  // input stops only after a transaction arrived during an output stall
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && out_valid && !out_ready))
    else $error("input ready dropped without output stall");

  // the skid holds one transaction at most, so ready comes back once output drains
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    !in_ready && (!out_valid || out_ready) |=> in_ready)
    else $error("input ready stuck low while pipe advances");

endmodule

bind gelu_tanh_fast_exp_top gtfe_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_gtfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .y_out     (y_out),
  .last_out  (last_out)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the streaming gelu (tanh form) activation unit
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import gtfe_pkg::*;

  localparam int DW          = 32;
  localparam int FB          = 24;
  localparam int N_RANDOM    = 600;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [DW-1:0] x_in;
  logic          last_in;
  logic          out_valid;
  logic          out_ready;
  logic [DW-1:0] y_out;
  logic          last_out;

  gelu_tanh_fast_exp_top #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .x_in     (x_in),
    .last_in  (last_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .y_out    (y_out),
    .last_out (last_out)
  );

  // one expected output transaction
  typedef struct {
    logic [DW-1:0] y;
    logic          last;
  } gelu_result_t;

  // one row of the directed table; pinned rows carry a hand-written result
  typedef struct packed {
    logic [DW-1:0] x;
    logic          last;
    logic          pinned;
    logic [DW-1:0] y;
  } directed_row_t;

  localparam int N_DIRECTED = 25;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},  // zero
    '{32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},  // smallest positive truncates to zero
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},  // smallest negative floors to -1 lsb
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},          // largest positive
    '{32'h8000_0000, 1'b1, 1'b0, 32'h0},          // most negative
    '{32'h0800_0000, 1'b0, 1'b0, 32'h0},          // exactly 8.0, clamp edge
    '{32'hF800_0000, 1'b0, 1'b0, 32'h0},          // exactly -8.0
    '{32'h07FF_FFFF, 1'b0, 1'b0, 32'h0},          // just under the clamp
    '{32'hF800_0001, 1'b1, 1'b0, 32'h0},
    '{32'h0800_0001, 1'b0, 1'b0, 32'h0},          // just over the clamp
    '{32'hF7FF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0100_0000, 1'b0, 1'b0, 32'h0},          // 1.0
    '{32'hFF00_0000, 1'b1, 1'b0, 32'h0},          // -1.0
    '{32'h0080_0000, 1'b0, 1'b0, 32'h0},          // 0.5
    '{32'hFF80_0000, 1'b0, 1'b0, 32'h0},          // -0.5
    '{32'h0000_1000, 1'b0, 1'b0, 32'h0},          // small u, tanh may dip below zero
    '{32'hFFFF_F000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0010, 1'b1, 1'b0, 32'h0},
    '{32'h0300_0000, 1'b0, 1'b0, 32'h0},          // 3.0
    '{32'hFD00_0000, 1'b0, 1'b0, 32'h0},          // -3.0
    '{32'h6400_0000, 1'b0, 1'b0, 32'h0},          // 100.0, far past the clamp
    '{32'h9C00_0000, 1'b1, 1'b0, 32'h0},          // -100.0
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0},          // alternating bits
    '{32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    '{32'h0040_0000, 1'b0, 1'b0, 32'h0}           // 0.25
  };

  gelu_result_t  pending_results[$];
  int            error_count;
  int            stall_cycles;
  int            n_inputs;
  int            n_negative;
  int            n_clamped;
  int            n_results;
  int            send_idle_pct;
  int            recv_idle_pct;
  logic          hold_off_request;
  logic          pin_valid;
  logic [DW-1:0] pin_y;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gelu of one activation: cubic in q26, shift-based exponential, q30 quotient
  function automatic logic [DW-1:0] gelu_of(input logic [DW-1:0] x);
    logic [DW-1:0] xn;
    logic [63:0]   ax, lim, clamp, xq, x2, x3, s, u, t, ti, tf, k, e, q, onep;
    logic [63:0]   hi, lo, lp, m, y;
    logic          neg, rem;
    neg   = x[DW-1];
    xn    = ~x + 1'b1;
    ax    = neg ? 64'(xn) : 64'(x);
    lim   = 64'(8) << FB;
    clamp = (ax < lim) ? ax : lim;
    if (UF >= FB) begin
      xq = clamp << (UF - FB);
    end else begin
      xq = clamp >> (FB - UF);
    end
    // u = sqrt(2/pi) * (x + 0.044715 x^3), saturated at 8
    x2 = (xq * xq) >> UF;
    x3 = (x2 * xq) >> UF;
    s  = xq + ((64'(C_CUBIC) * x3) >> QF);
    u  = (64'(C_SQ2PI) * s) >> QF;
    if (u > (64'(8) << UF)) begin
      u = 64'(8) << UF;
    end
    // e ~ 2^t with t = 2 |u| log2e, linear mantissa
    t  = ((u << 1) * 64'(C_LOG2E)) >> QF;
    ti = t >> UF;
    tf = t & ((64'(1) << UF) - 64'(1));
    if (ti > 64'(31)) begin
      ti = 64'(31);
    end
    k    = ((64'(C_SLOPE) * tf) >> UF) + 64'(C_ICEPT);
    e    = k << ti;
    q    = (64'(1) << 61) / (e + 64'(ONE_Q30));
    onep = neg ? q : (64'(ONE_Q30) + 64'(ONE_Q30) - q);
    // |x| * (1 + tanh) / 2, floor toward minus infinity
    hi  = ax >> 32;
    lo  = ax & 64'hFFFF_FFFF;
    lp  = lo * onep;
    m   = ((hi * onep) << 1) + (lp >> 31);
    rem = |lp[30:0];
    if (neg) begin
      if (rem) begin
        m = m + 64'(1);
      end
      y = ~m + 64'(1);
    end else begin
      y = m;
    end
    return y[DW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t ns", what, got, want, $time);
    error_count++;
  endtask

  // offer one activation and return at the edge where it is taken
  task automatic offer_activation(input logic [DW-1:0] x, input logic lst,
                                  input logic pinned, input logic [DW-1:0] y);
    logic took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pin_valid = pinned;
    pin_y     = y;
    in_valid <= 1'b1;
    x_in     <= x;
    last_in  <= lst;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pin_valid = 1'b0;
  endtask

  // monitor: sample both channels mid-cycle, away from the driving edge
  always @(negedge clk) begin : monitor
    gelu_result_t want;
    logic         moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        want.y    = pin_valid ? pin_y : gelu_of(x_in);
        want.last = last_in;
        pending_results.push_back(want);
        n_inputs++;
        if (x_in[DW-1]) n_negative++;
        if (x_in >= 32'h0800_0000 && x_in <= 32'hF800_0000) n_clamped++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", y_out, '0);
        end else begin
          want = pending_results.pop_front();
          if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
          if (last_out !== want.last) begin
            report_mismatch("last_out", DW'(last_out), DW'(want.last));
          end
        end
        moved = 1'b1;
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  // receiver: random back-pressure, plus one long hold-off to fill the pipe
  initial begin : receiver
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout after %0d idle cycles", stall_cycles);
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [DW-1:0] mag;
    logic [DW-1:0] xv;
    logic          lst;
    int            r;
    error_count      = 0;
    stall_cycles     = 0;
    n_inputs         = 0;
    n_negative       = 0;
    n_clamped        = 0;
    n_results        = 0;
    pin_valid        = 1'b0;
    pin_y            = '0;
    hold_off_request = 1'b0;
    send_idle_pct    = 22;
    recv_idle_pct    = 54;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    x_in     <= '0;
    last_in  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_activation(DIRECTED[i].x, DIRECTED[i].last, DIRECTED[i].pinned, DIRECTED[i].y);
    end

    // random activations, mostly inside the clamp range
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 22;
      end
      if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_off_request = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        mag = $urandom_range(0, 32'h0800_0000);
      end else if (r < 75) begin
        mag = $urandom_range(0, 32'h0001_0000);
      end else if (r < 90) begin
        mag = $urandom();
      end else begin
        mag = 32'h0800_0000 + $urandom_range(0, 32) - 16;
      end
      xv  = $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
      lst = ($urandom_range(0, 7) == 0);
      offer_activation(xv, lst, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d activations (%0d negative, %0d at or past the clamp of 8)",
             n_inputs, n_negative, n_clamped);
    $display("%0d results checked under three idling mixes and one long output hold-off",
             n_results);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
